// ===== hw/rtl/slc_pkg.sv =====
// Shared types and constants of the set-associative LRU cache lookup core.
// No dependencies; used by the top level by scoped names.
package slc_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 4;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 4'd1;

  localparam logic [CFG_DATA_W-1:0] WAYS_IN_USE_RST = 4'd8;
  localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST = 4'd4;

  localparam int unsigned COUNT_W = 32;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

endpackage

// ===== hw/rtl/slc_row_ram.sv =====
// Set row storage: valid bits, recency ranks and tags of all ways of a set.
// One write port, one registered read port. No package dependencies.
module slc_row_ram #(
  parameter int unsigned SET_W    = 6,
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned WAYS     = 8,
  parameter int unsigned RW       = 3,
  parameter int unsigned TAG_W    = 26
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [SET_W-1:0]               waddr_i,
  input  logic [WAYS-1:0]                wvld_i,
  input  logic [WAYS-1:0][RW-1:0]        wrank_i,
  input  logic [WAYS-1:0][TAG_W-1:0]     wtag_i,
  input  logic                           re_i,
  input  logic [SET_W-1:0]               raddr_i,
  output logic [WAYS-1:0]                rvld_o,
  output logic [WAYS-1:0][RW-1:0]        rrank_o,
  output logic [WAYS-1:0][TAG_W-1:0]     rtag_o
);

  logic [WAYS-1:0]            vld_mem  [NUM_SETS];
  logic [WAYS-1:0][RW-1:0]    rank_mem [NUM_SETS];
  logic [WAYS-1:0][TAG_W-1:0] tag_mem  [NUM_SETS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      vld_mem[waddr_i]  <= wvld_i;
      rank_mem[waddr_i] <= wrank_i;
      tag_mem[waddr_i]  <= wtag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rvld_o  <= vld_mem[raddr_i];
      rrank_o <= rank_mem[raddr_i];
      rtag_o  <= tag_mem[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/slc_way_update.sv =====
// Combinational tag compare, victim choice and LRU rank update for one set row.
// No package dependencies; instantiated by the top level.
module slc_way_update #(
  parameter int unsigned WAYS  = 8,
  parameter int unsigned RW    = 3,
  parameter int unsigned TAG_W = 26,
  parameter int unsigned WC_W  = 4
) (
  input  logic [WC_W-1:0]              ways_i,   // effective ways, 1..WAYS
  input  logic [TAG_W-1:0]             tag_i,
  input  logic [WAYS-1:0]              vld_i,
  input  logic [WAYS-1:0][RW-1:0]      rank_i,
  input  logic [WAYS-1:0][TAG_W-1:0]   tags_i,
  output logic                         hit_o,
  output logic [WAYS-1:0]              vld_o,
  output logic [WAYS-1:0][RW-1:0]      rank_o,
  output logic [WAYS-1:0][TAG_W-1:0]   tags_o
);

  logic [WAYS-1:0] inuse;
  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] free_vec;
  logic [WAYS-1:0] hit_oh;
  logic [WAYS-1:0] free_oh;
  logic [WAYS-1:0] vic_oh;
  logic [WAYS-1:0] hot_oh;
  logic            any_free;
  logic [RW-1:0]   hot_rank;
  logic [RW-1:0]   oldest;
  logic [WC_W-1:0] limit;
  logic [WC_W-1:0] age_cap;

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      inuse[j]    = WC_W'(j) < ways_i;
      hit_vec[j]  = inuse[j] & vld_i[j] & (tags_i[j] == tag_i);
      free_vec[j] = inuse[j] & ~vld_i[j];
    end
  end

  // first in-use way holding the largest rank
  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      vic_oh[j] = inuse[j];
      for (int k = 0; k < WAYS; k++) begin
        if (k < j && inuse[k] && rank_i[k] >= rank_i[j]) vic_oh[j] = 1'b0;
        if (k > j && inuse[k] && rank_i[k] > rank_i[j])  vic_oh[j] = 1'b0;
      end
    end
  end

  assign hit_oh   = hit_vec & (~hit_vec + WAYS'(1));
  assign free_oh  = free_vec & (~free_vec + WAYS'(1));
  assign hit_o    = |hit_vec;
  assign any_free = |free_vec;
  assign hot_oh   = hit_o ? hit_oh : (any_free ? free_oh : vic_oh);
  assign age_cap  = ways_i - WC_W'(1);

  always_comb begin
    hot_rank = '0;
    oldest   = '0;
    for (int j = 0; j < WAYS; j++) begin
      if (hot_oh[j]) hot_rank = hot_rank | rank_i[j];
      if (vic_oh[j]) oldest   = oldest | rank_i[j];
    end
  end

  always_comb begin
    if (hit_o) begin
      limit = WC_W'(hot_rank);
    end else if (any_free) begin
      limit = ways_i;
    end else begin
      limit = WC_W'(oldest);
    end
  end

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      vld_o[j]  = vld_i[j] | hot_oh[j];
      tags_o[j] = hot_oh[j] ? tag_i : tags_i[j];
      if (hot_oh[j]) begin
        rank_o[j] = '0;
      end else if (inuse[j] && vld_i[j] && (WC_W'(rank_i[j]) < limit) &&
                   (WC_W'(rank_i[j]) < age_cap)) begin
        rank_o[j] = rank_i[j] + RW'(1);
      end else begin
        rank_o[j] = rank_i[j];
      end
    end
  end

endmodule

// ===== hw/rtl/set_assoc_lru_cache_lookup_core.sv =====
// Top level of the set-associative LRU cache lookup core.
// Depends on slc_pkg, slc_row_ram and slc_way_update.
//
// Usage: each input beat on the in channel carries one byte address; each
// output beat carries hit plus the running saturating hit and miss counts
// including that access. Both channels use valid/ready.
// The cfg channel writes ways_in_use (index 0) and offset_bits (index 1);
// it is always ready; the user must write it only while the core is idle,
// which the core itself does not enforce. Path: the set row is read into
// a register, then compare/update loads the output register.
// Throughput: one address per cycle while out_ready_i allows, back to back
// even to the same set; the updated row is forwarded to the next access, so
// the single read and write port of the row memory sets the rate.
// Reset: a clearing sweep writes every set row, one per cycle, during which
// in_ready_o stays low.
// Stall: when out_ready_i is low the result waits in the output register;
// one more address is taken and held, after that in_ready_o drops.
module set_assoc_lru_cache_lookup_core #(
  parameter int unsigned ADDR_BITS  = 32,
  parameter int unsigned INDEX_BITS = 6,
  parameter int unsigned WAYS       = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [slc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [slc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ADDR_BITS-1:0]               address_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               hit_o,
  output logic [slc_pkg::COUNT_W-1:0]        hit_count_o,
  output logic [slc_pkg::COUNT_W-1:0]        miss_count_o
);

  localparam int unsigned SET_W    = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int unsigned NUM_SETS = 1 << INDEX_BITS;
  localparam int unsigned TAG_W    = ADDR_BITS - INDEX_BITS;
  localparam int unsigned RW       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WC_W     = $clog2(WAYS + 1);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);
  localparam logic [slc_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  // configuration
  logic [slc_pkg::CFG_DATA_W-1:0] ways_q;
  logic [slc_pkg::CFG_DATA_W-1:0] offset_q;
  logic [WC_W-1:0]                ways_eff;

  // control
  slc_pkg::state_e state_q, state_d;
  logic [SET_W-1:0] clr_q;
  logic             clearing;
  logic             s1_valid_q;
  logic             out_valid_q;
  logic             in_fire;
  logic             s1_fire;

  // datapath
  logic [ADDR_BITS-1:0] in_shifted;
  logic [SET_W-1:0]     in_set;
  logic [ADDR_BITS-1:0] s1_addr_q;
  logic [SET_W-1:0]     s1_set_q;
  logic [ADDR_BITS-1:0] s1_shifted;
  logic [TAG_W-1:0]     s1_tag;
  logic                 fwd_q;
  logic [WAYS-1:0]            fwd_vld_q;
  logic [WAYS-1:0][RW-1:0]    fwd_rank_q;
  logic [WAYS-1:0][TAG_W-1:0] fwd_tag_q;
  logic [WAYS-1:0]            ram_vld;
  logic [WAYS-1:0][RW-1:0]    ram_rank;
  logic [WAYS-1:0][TAG_W-1:0] ram_tag;
  logic [WAYS-1:0]            row_vld;
  logic [WAYS-1:0][RW-1:0]    row_rank;
  logic [WAYS-1:0][TAG_W-1:0] row_tag;
  logic [WAYS-1:0]            new_vld;
  logic [WAYS-1:0][RW-1:0]    new_rank;
  logic [WAYS-1:0][TAG_W-1:0] new_tag;
  logic                       lu_hit;
  logic                       we;
  logic [SET_W-1:0]           waddr;
  logic [WAYS-1:0]            wvld;
  logic [WAYS-1:0][RW-1:0]    wrank;
  logic [WAYS-1:0][TAG_W-1:0] wtag;
  logic                       hit_q;
  logic [slc_pkg::COUNT_W-1:0] hits_q;
  logic [slc_pkg::COUNT_W-1:0] misses_q;

  // ---------------- configuration registers ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q   <= slc_pkg::WAYS_IN_USE_RST;
      offset_q <= slc_pkg::OFFSET_BITS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        slc_pkg::CFG_WAYS_IN_USE: ways_q   <= cfg_data_i;
        slc_pkg::CFG_OFFSET_BITS: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ways_q == '0) begin
      ways_eff = WC_W'(1);
    end else if (32'(ways_q) > WAYS) begin
      ways_eff = WC_W'(WAYS);
    end else begin
      ways_eff = WC_W'(ways_q);
    end
  end

  // ---------------- clearing sweep after reset ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      slc_pkg::ST_CLEAR: if (clr_q == LAST_SET) state_d = slc_pkg::ST_RUN;
      slc_pkg::ST_RUN:   state_d = slc_pkg::ST_RUN;
      default:           state_d = slc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    case (state_q)
      slc_pkg::ST_CLEAR: clearing = 1'b1;
      slc_pkg::ST_RUN:   clearing = 1'b0;
      default:           clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slc_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_q <= clr_q + SET_W'(1);
    end
  end

  // ---------------- handshake ----------------
  assign s1_fire     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~clearing & (~s1_valid_q | s1_fire);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- address split ----------------
  assign in_shifted = address_i >> offset_q;
  assign in_set     = (INDEX_BITS == 0) ? '0 : in_shifted[SET_W-1:0];
  assign s1_shifted = s1_addr_q >> offset_q;
  assign s1_tag     = TAG_W'(s1_shifted >> INDEX_BITS);

  // beat in stage 1 retiring now updates the same set: forward its new row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_fire) begin
      fwd_q <= s1_fire & (in_set == s1_set_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q  <= address_i;
      s1_set_q   <= in_set;
      fwd_vld_q  <= new_vld;
      fwd_rank_q <= new_rank;
      fwd_tag_q  <= new_tag;
    end
  end

  // ---------------- row memory ----------------
  assign we    = clearing | s1_fire;
  assign waddr = clearing ? clr_q : s1_set_q;
  assign wvld  = clearing ? '0 : new_vld;
  assign wrank = clearing ? '0 : new_rank;
  assign wtag  = clearing ? '0 : new_tag;

  slc_row_ram #(
    .SET_W    (SET_W),
    .NUM_SETS (NUM_SETS),
    .WAYS     (WAYS),
    .RW       (RW),
    .TAG_W    (TAG_W)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wvld_i  (wvld),
    .wrank_i (wrank),
    .wtag_i  (wtag),
    .re_i    (in_fire),
    .raddr_i (in_set),
    .rvld_o  (ram_vld),
    .rrank_o (ram_rank),
    .rtag_o  (ram_tag)
  );

  assign row_vld  = fwd_q ? fwd_vld_q  : ram_vld;
  assign row_rank = fwd_q ? fwd_rank_q : ram_rank;
  assign row_tag  = fwd_q ? fwd_tag_q  : ram_tag;

  // ---------------- lookup and LRU update ----------------
  slc_way_update #(
    .WAYS  (WAYS),
    .RW    (RW),
    .TAG_W (TAG_W),
    .WC_W  (WC_W)
  ) u_way_update (
    .ways_i (ways_eff),
    .tag_i  (s1_tag),
    .vld_i  (row_vld),
    .rank_i (row_rank),
    .tags_i (row_tag),
    .hit_o  (lu_hit),
    .vld_o  (new_vld),
    .rank_o (new_rank),
    .tags_o (new_tag)
  );

  // ---------------- result register and counters ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
    end else if (s1_fire) begin
      if (lu_hit) begin
        if (hits_q != COUNT_MAX) hits_q <= hits_q + 1'b1;
      end else begin
        if (misses_q != COUNT_MAX) misses_q <= misses_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) hit_q <= lu_hit;
  end

  // counters only move when a new result loads, so they track the held beat
  assign hit_o        = hit_q;
  assign hit_count_o  = hits_q;
  assign miss_count_o = misses_q;

endmodule

// ===== test/tb.sv =====
// Self-checking bench for set_assoc_lru_cache_lookup_core: directed table then random traffic,
// results compared against an LRU set/way tracker kept in the bench.
// Depends on slc_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned SET_W       = 6;
  localparam int unsigned NSETS       = 1 << SET_W;
  localparam int unsigned NWAYS       = 8;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_WAIT  = 4;
  localparam int unsigned SEG_ITEMS   = 128;
  localparam logic [slc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 4'hE;

  typedef struct packed {
    logic        hit;
    logic [31:0] hits;
    logic [31:0] misses;
  } lookup_res_t;

  typedef enum logic { ROW_ACC, ROW_CFG } row_kind_e;

  typedef struct packed {
    row_kind_e                         kind;
    logic [slc_pkg::CFG_IDX_W-1:0]     idx;
    logic [slc_pkg::CFG_DATA_W-1:0]    data;
    logic [ADDR_W-1:0]                 addr;
    logic                              typed;
    lookup_res_t                       res;
  } stim_row_t;

  localparam lookup_res_t NO_RES = '0;
  localparam int unsigned N_DIR = 36;

  // typed results only for the first few lookups after reset
  stim_row_t dir_rows [N_DIR] = '{
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'd0, 32'd1}},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_0000, 1'b1, '{1'b1, 32'd1, 32'd1}},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_000F, 1'b1, '{1'b1, 32'd2, 32'd1}},
    '{ROW_ACC, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd2, 32'd2}},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_0010, 1'b1, '{1'b0, 32'd2, 32'd3}},
    // fill set 0, the ninth tag evicts the oldest line
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_0400, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_0800, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_0C00, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_1000, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_1400, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_1800, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_1C00, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_2000, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_2000, 1'b0, NO_RES},
    // shrink ways: line in an upper way must be ignored
    '{ROW_CFG, slc_pkg::CFG_WAYS_IN_USE, 4'd2, 32'h0, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_1C00, 1'b0, NO_RES},
    '{ROW_CFG, slc_pkg::CFG_WAYS_IN_USE, 4'd0, 32'h0, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_1C00, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_1C00, 1'b0, NO_RES},
    '{ROW_CFG, slc_pkg::CFG_WAYS_IN_USE, 4'd15, 32'h0, 1'b0, NO_RES},
    '{ROW_CFG, slc_pkg::CFG_OFFSET_BITS, 4'd0, 32'h0, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h0000_0040, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, NO_RES},
    '{ROW_CFG, slc_pkg::CFG_OFFSET_BITS, 4'd15, 32'h0, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h8000_0000, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b0, NO_RES},
    '{ROW_CFG, slc_pkg::CFG_OFFSET_BITS, 4'd8, 32'h0, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'hAAAA_AAAA, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h5555_5555, 1'b0, NO_RES},
    '{ROW_CFG, CFG_UNUSED, 4'd5, 32'h0, 1'b0, NO_RES},
    '{ROW_CFG, slc_pkg::CFG_WAYS_IN_USE, 4'd1, 32'h0, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h1234_5678, 1'b0, NO_RES},
    '{ROW_ACC, 4'd0, 4'd0, 32'h1234_5678, 1'b0, NO_RES},
    '{ROW_CFG, slc_pkg::CFG_WAYS_IN_USE, 4'd8, 32'h0, 1'b0, NO_RES},
    '{ROW_CFG, slc_pkg::CFG_OFFSET_BITS, 4'd4, 32'h0, 1'b0, NO_RES}
  };

  logic                            clk_i;
  logic                            rst_ni       = 1'b0;
  logic                            cfg_valid_i  = 1'b0;
  logic                            cfg_ready_o;
  logic [slc_pkg::CFG_IDX_W-1:0]   cfg_index_i  = '0;
  logic [slc_pkg::CFG_DATA_W-1:0]  cfg_data_i   = '0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_ready_o;
  logic [ADDR_W-1:0]               address_i    = '0;
  logic                            out_valid_o;
  logic                            out_ready_i  = 1'b0;
  logic                            hit_o;
  logic [slc_pkg::COUNT_W-1:0]     hit_count_o;
  logic [slc_pkg::COUNT_W-1:0]     miss_count_o;

  // typed expectation travels with the address beat
  logic                            cur_typed    = 1'b0;
  lookup_res_t                     cur_res      = '0;

  int unsigned src_idle_pct = 34;
  int unsigned dst_idle_pct = 53;
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  int unsigned result_beats = 0;
  bit          moved;

  // shadow of the cache state
  logic [3:0]  ways_reg = slc_pkg::WAYS_IN_USE_RST;
  logic [3:0]  off_reg  = slc_pkg::OFFSET_BITS_RST;
  logic [31:0] line_tag [NSETS][NWAYS];
  bit          line_vld [NSETS][NWAYS];
  int unsigned line_age [NSETS][NWAYS];
  logic [31:0] hits_seen   = '0;
  logic [31:0] misses_seen = '0;
  lookup_res_t pending_results [$];

  set_assoc_lru_cache_lookup_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .hit_count_o  (hit_count_o),
    .miss_count_o (miss_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (int s = 0; s < NSETS; s++) begin
      for (int j = 0; j < NWAYS; j++) begin
        line_tag[s][j] = '0;
        line_vld[s][j] = 1'b0;
        line_age[s][j] = 0;
      end
    end
  end

  function automatic int unsigned eff_ways(input logic [3:0] w);
    if (w == 0) return 1;
    if (w > NWAYS) return NWAYS;
    return w;
  endfunction

  // promote 'hot' to MRU; younger valid lines age by one, capped at w-1
  function automatic void age_set(input int unsigned s, input int unsigned hot,
                                  input int unsigned limit, input int unsigned w);
    for (int unsigned j = 0; j < w; j++) begin
      if (j != hot && line_vld[s][j] && line_age[s][j] < limit && line_age[s][j] < w - 1)
        line_age[s][j] = line_age[s][j] + 1;
    end
    line_age[s][hot] = 0;
  endfunction

  function automatic lookup_res_t predict_lookup(input logic [ADDR_W-1:0] a);
    int unsigned w;
    int unsigned s;
    int unsigned way;
    int unsigned oldest;
    int unsigned limit;
    logic [31:0] tag;
    bit          found;
    bit          has_free;
    lookup_res_t r;
    w     = eff_ways(ways_reg);
    s     = (a >> off_reg) & (NSETS - 1);
    tag   = a >> (off_reg + SET_W);
    found = 1'b0;
    way   = 0;
    for (int unsigned j = 0; j < w; j++) begin
      if (!found && line_vld[s][j] && line_tag[s][j] == tag) begin
        found = 1'b1;
        way   = j;
      end
    end
    if (found) begin
      age_set(s, way, line_age[s][way], w);
      if (hits_seen != '1) hits_seen = hits_seen + 1;
    end else begin
      has_free = 1'b0;
      for (int unsigned j = 0; j < w; j++) begin
        if (!has_free && !line_vld[s][j]) begin
          has_free = 1'b1;
          way      = j;
        end
      end
      if (has_free) begin
        limit = w;
      end else begin
        oldest = 0;
        way    = 0;
        for (int unsigned j = 0; j < w; j++) begin
          if (line_age[s][j] > oldest) begin
            oldest = line_age[s][j];
            way    = j;
          end
        end
        limit = oldest;
      end
      line_tag[s][way] = tag;
      line_vld[s][way] = 1'b1;
      age_set(s, way, limit, w);
      if (misses_seen != '1) misses_seen = misses_seen + 1;
    end
    r.hit    = found;
    r.hits   = hits_seen;
    r.misses = misses_seen;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result beat %0d: %s got %0h want %0h", $time, result_beats, field,
             got, want);
    mismatches = mismatches + 1;
  endtask

  // one monitor for all channels so prediction and checking never race
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_index_i)
          slc_pkg::CFG_WAYS_IN_USE: ways_reg = cfg_data_i;
          slc_pkg::CFG_OFFSET_BITS: off_reg  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        lookup_res_t r;
        moved = 1'b1;
        r = predict_lookup(address_i);
        if (cur_typed) r = cur_res;
        pending_results = {pending_results, r};
      end
      if (out_valid_o && out_ready_i) begin
        lookup_res_t want;
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", {31'd0, hit_o}, 32'd0);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (hit_o !== want.hit) report_mismatch("hit", {31'd0, hit_o}, {31'd0, want.hit});
          if (hit_count_o !== want.hits) report_mismatch("hit_count", hit_count_o, want.hits);
          if (miss_count_o !== want.misses)
            report_mismatch("miss_count", miss_count_o, want.misses);
        end
        result_beats = result_beats + 1;
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("FAIL set_assoc_lru_cache_lookup_core");
          $finish;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= dst_idle_pct);
  end

  task automatic push_address(input logic [ADDR_W-1:0] a, input logic typed,
                              input lookup_res_t res);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i <= 1'b1;
    address_i  <= a;
    cur_typed  <= typed;
    cur_res    <= res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [slc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [slc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // quiesce: no beat in flight and core ready
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || !in_ready_o) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [3:0] pick_nibble(input logic [3:0] lo, input logic [3:0] hi);
    case ($urandom_range(3))
      0:       return lo;
      1:       return hi;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  initial begin
    logic [3:0]  ways_pick;
    logic [3:0]  off_pick;
    logic [31:0] set_base;
    logic [31:0] tag_base;
    logic [31:0] tag;
    logic [31:0] set_sel;
    logic [31:0] a;
    int unsigned n_tags;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle();
        cfg_write(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        push_address(dir_rows[r].addr, dir_rows[r].typed, dir_rows[r].res);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 34; dst_idle_pct = 53; end
        1: begin src_idle_pct = 53; dst_idle_pct = 34; end
        default: begin src_idle_pct = 0; dst_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        settle();
        ways_pick = pick_nibble(4'd1, 4'd8);
        off_pick  = pick_nibble(4'd0, 4'd15);
        cfg_write(slc_pkg::CFG_WAYS_IN_USE, ways_pick);
        cfg_write(slc_pkg::CFG_OFFSET_BITS, off_pick);
        set_base = $urandom;
        tag_base = $urandom;
        // up to three more tags than ways so sets see both reuse and eviction
        n_tags   = eff_ways(ways_pick) + $urandom_range(3);
        for (int k = 0; k < SEG_ITEMS; k++) begin
          if ($urandom_range(99) < 15) begin
            a = $urandom;
          end else begin
            tag     = tag_base + $urandom_range(n_tags - 1);
            set_sel = (set_base + $urandom_range(3)) & (NSETS - 1);
            a = (tag << (off_pick + SET_W)) | (set_sel << off_pick)
              | ($urandom & ((32'd1 << off_pick) - 1));
          end
          push_address(a, 1'b0, NO_RES);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS set_assoc_lru_cache_lookup_core");
    end else begin
      $display("FAIL set_assoc_lru_cache_lookup_core");
    end
    $finish;
  end

endmodule
